@@ rtl/bfta_pkg.sv @@
// shared types and constants of the best-fit tagged allocator
`timescale 1ns / 1ps
package bfta_pkg;

    localparam int TAG_W  = 20;
    localparam int REQ_W  = 24;
    localparam int SIZE_W = 32;
    localparam int PAGE_W = 24;

    localparam int DEF_MAX_BLOCKS = 256;
    localparam logic [PAGE_W-1:0] DEF_PAGE_SIZE = 24'd1000;
    localparam logic [SIZE_W-1:0] SAT32 = '1;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_opcode;

    typedef enum logic {
        ST_DONE = 1'b0,
        ST_FULL = 1'b1
    } t_status;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [SIZE_W-1:0] size;
        logic              is_free;
    } t_entry;

    typedef struct packed {
        logic              start;
        logic [REQ_W-1:0]  dividend;
        logic [PAGE_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [REQ_W-1:0]  quo;
        logic [PAGE_W-1:0] rem;
    } t_div_rsp;

endpackage

@@ rtl/bfta_ram.sv @@
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module bfta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/bfta_div.sv @@
// restoring divider for the page count, one quotient bit per cycle
`timescale 1ns / 1ps
module bfta_div
    import bfta_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(REQ_W + 1);

    logic [PAGE_W:0]      r_acc;
    logic [REQ_W-1:0]     r_quo;
    logic [PAGE_W-1:0]    r_dvs;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [PAGE_W:0]      shifted;
    logic [PAGE_W:0]      trial;

    assign shifted = {r_acc[PAGE_W-1:0], r_quo[REQ_W-1]};
    assign trial   = shifted - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_acc  <= '0;
                r_quo  <= i_req.dividend;
                r_dvs  <= i_req.divisor;
                r_cnt  <= CNT_W'(REQ_W);
            end else if (r_busy) begin
                if (!trial[PAGE_W]) begin
                    r_acc <= trial;
                    r_quo <= {r_quo[REQ_W-2:0], 1'b1};
                end else begin
                    r_acc <= shifted;
                    r_quo <= {r_quo[REQ_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_acc[PAGE_W-1:0];

`ifndef SYNTHESIS
    a_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("divider done held for two cycles");
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_cnt != CNT_W'(1) |=> r_busy || i_req.start)
        else $error("divider stopped early");
`endif

endmodule

@@ rtl/best_fit_tagged_allocator_core.sv @@
// top level of the best-fit tagged allocator: sequencer over the block table ram
`timescale 1ns / 1ps
// Best-fit allocator over an address-ordered block table kept in one ram of
// MAX_BLOCKS entries (tag, size, free bit). One request is handled at a time;
// o_in_stall is high while a request is in work. Every read of the table goes
// through the single registered read port, one entry per cycle, so the cost
// is set by the number of blocks N in use: an allocate scans the table to find
// its block, then either runs the page divider when the tail has to grow (the
// tail is then the pick, so no slot has to be opened) or shifts entries up to
// open a slot for the split; an exact fit of a non-tail block is taken in
// place, and a split into a full table ends with status full. A free makes one
// release-and-merge pass. Every request ends with one more pass that finds the
// largest free block. After reset the S_INIT state writes the initial empty
// tail block; nothing is accepted in that state. The result sits in an output
// register, so the next request may be accepted once the block is back in idle
// even while that result waits. The page size register is written through its
// own port; the user must write it only while idle, which the block does not
// enforce. A value of zero acts as one.
module best_fit_tagged_allocator_core
    import bfta_pkg::*;
#(
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_opcode,
    input  logic [TAG_W-1:0]  i_tag,
    input  logic [REQ_W-1:0]  i_size,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_status,
    output logic [31:0]       o_pages_requested,
    output logic [31:0]       o_largest_free,
    // page size register
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [PAGE_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_SCAN, S_DECIDE, S_DIV, S_SHIFT,
        S_PLACE0, S_PLACE1, S_FREE, S_FREE_END, S_LARGE, S_OUT
    } t_state;

    t_state            r_state;
    logic [CW-1:0]     r_count;
    logic [SIZE_W-1:0] r_page_total;
    logic [PAGE_W-1:0] r_page_size;

    // request being worked on
    logic [TAG_W-1:0]  r_tag;
    logic [REQ_W-1:0]  r_req;
    logic              r_status;

    // read pipeline: issue index and the index whose data is in q
    logic [CW-1:0]     r_ra;
    logic              r_dv;
    logic [AW-1:0]     r_di;

    // best-fit pick
    logic [AW-1:0]     r_pick;
    logic              r_pick_vld;
    logic [SIZE_W-1:0] r_pick_sz;
    logic [SIZE_W-1:0] r_tail_sz;
    logic [REQ_W-1:0]  r_need;

    // merge pass
    t_entry            r_held;
    logic              r_hv;
    logic [AW-1:0]     r_wr;

    logic [SIZE_W-1:0] r_best;

    // output register
    logic              r_ovld;
    logic              r_ostat;
    logic [SIZE_W-1:0] r_opages;
    logic [SIZE_W-1:0] r_olarge;

    logic              r_div_start;
    t_div_req          div_req;
    t_div_rsp          div_rsp;

    t_entry            q;
    logic [$bits(t_entry)-1:0] q_bits;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    t_entry            ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic              issue;

    logic [CW-1:0]     last;
    logic              last_proc;
    logic              pick_is_tail;
    logic              split;
    logic              full;
    logic              div_go;
    logic [PAGE_W-1:0] ps_eff;
    t_entry            e_rel;
    logic              do_merge;
    logic [SIZE_W:0]   merge_sum;
    logic [PAGE_W:0]   round_up;
    logic [SIZE_W:0]   pt_sum;
    logic              fits;
    logic              better;

    assign q         = t_entry'(q_bits);
    assign ram_raddr = r_ra[AW-1:0];
    assign last      = r_count - 1'b1;
    assign last_proc = (CW'(r_di) == last);
    assign pick_is_tail = (CW'(r_pick) == last);
    assign split     = pick_is_tail || (r_pick_sz != SIZE_W'(r_req));
    assign full      = (r_count >= CW'(MAX_BLOCKS));
    assign ps_eff    = (r_page_size == '0) ? PAGE_W'(1) : r_page_size;

    // tail has to grow: start the page divider
    assign div_go = (r_state == S_DECIDE) && split && !full &&
                    (r_pick_sz < SIZE_W'(r_req));

    // scan compare: free, big enough, strictly smaller keeps the lower position
    assign fits   = q.is_free && (q.size >= SIZE_W'(r_req));
    assign better = !r_pick_vld || (q.size < r_pick_sz);

    // release by tag, then merge with a free block held from before
    always_comb begin
        e_rel = q;
        if (!q.is_free && (q.tag == r_tag)) begin
            e_rel.is_free = 1'b1;
        end
    end
    assign do_merge  = r_hv && r_held.is_free && e_rel.is_free;
    assign merge_sum = {1'b0, r_held.size} + {1'b0, e_rel.size};

    // pages times page size is the need rounded up to a whole page
    assign round_up = {1'b0, r_need} +
                      ((div_rsp.rem != '0) ? {1'b0, ps_eff - div_rsp.rem} : '0);
    // page count is the quotient, plus one for a partial page
    assign pt_sum   = {1'b0, r_page_total} + (SIZE_W + 1)'(div_rsp.quo) +
                      (SIZE_W + 1)'(div_rsp.rem != '0);

    assign div_req.start    = r_div_start;
    assign div_req.dividend = r_need;
    assign div_req.divisor  = ps_eff;

    // table port control
    always_comb begin
        issue     = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = q;
        unique case (r_state)
            S_INIT: begin
                ram_we    = 1'b1;
                ram_wdata = '{tag: '0, size: '0, is_free: 1'b1};
            end
            S_SCAN, S_LARGE: begin
                issue = (r_ra < r_count);
            end
            S_FREE: begin
                issue = (r_ra < r_count);
                if (r_dv && r_hv && !do_merge) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_wr;
                    ram_wdata = r_held;
                end
            end
            S_FREE_END: begin
                ram_we    = 1'b1;
                ram_waddr = r_wr;
                ram_wdata = r_held;
            end
            S_DECIDE: begin
                // exact fit of a non-tail block: taken whole in place
                if (!split) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_pick;
                    ram_wdata = '{tag: r_tag, size: r_pick_sz, is_free: 1'b0};
                end
            end
            S_SHIFT: begin
                // move entries above the pick up by one, top first
                issue = (r_ra > CW'(r_pick));
                if (r_dv) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_di + 1'b1;
                    ram_wdata = q;
                end
            end
            S_PLACE0: begin
                ram_we    = 1'b1;
                ram_waddr = r_pick + 1'b1;
                ram_wdata = '{tag: r_tag, size: r_pick_sz - SIZE_W'(r_req), is_free: 1'b1};
            end
            S_PLACE1: begin
                ram_we    = 1'b1;
                ram_waddr = r_pick;
                ram_wdata = '{tag: r_tag, size: SIZE_W'(r_req), is_free: 1'b0};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_count      <= CW'(1);
            r_page_total <= '0;
            r_page_size  <= DEF_PAGE_SIZE;
            r_ovld       <= 1'b0;
            r_dv         <= 1'b0;
            r_div_start  <= 1'b0;
        end else begin
            r_div_start <= div_go;
            r_dv        <= issue;
            r_di        <= r_ra[AW-1:0];

            if (i_cfg_valid) begin
                r_page_size <= i_cfg_data;
            end
            // result register: load in S_OUT, clear when the beat is taken
            if ((r_state == S_OUT) && (!r_ovld || !i_out_stall)) begin
                r_ovld <= 1'b1;
            end else if (r_ovld && !i_out_stall) begin
                r_ovld <= 1'b0;
            end

            unique case (r_state)
                S_INIT: begin
                    r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_tag      <= i_tag;
                        r_req      <= i_size;
                        r_status   <= ST_DONE;
                        r_ra       <= '0;
                        r_pick_vld <= 1'b0;
                        r_hv       <= 1'b0;
                        r_wr       <= '0;
                        r_state    <= (i_opcode == OP_FREE) ? S_FREE : S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (issue) begin
                        r_ra <= r_ra + 1'b1;
                    end
                    if (r_dv) begin
                        if (fits && better) begin
                            r_pick     <= r_di;
                            r_pick_vld <= 1'b1;
                            r_pick_sz  <= q.size;
                        end
                        if (last_proc) begin
                            r_tail_sz <= q.size;
                        end
                    end else if (r_ra >= r_count) begin
                        // nothing fits: fall back on the tail
                        if (!r_pick_vld) begin
                            r_pick    <= last[AW-1:0];
                            r_pick_sz <= r_tail_sz;
                        end
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (!split) begin
                        r_ra    <= '0;
                        r_best  <= '0;
                        r_state <= S_LARGE;
                    end else if (full) begin
                        r_status <= ST_FULL;
                        r_ra     <= '0;
                        r_best   <= '0;
                        r_state  <= S_LARGE;
                    end else if (r_pick_sz < SIZE_W'(r_req)) begin
                        r_ra    <= last;
                        r_need  <= r_req - r_pick_sz[REQ_W-1:0];
                        r_state <= S_DIV;
                    end else begin
                        r_ra    <= last;
                        r_state <= S_SHIFT;
                    end
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_pick_sz    <= r_pick_sz + SIZE_W'(round_up);
                        r_page_total <= pt_sum[SIZE_W] ? SAT32 : pt_sum[SIZE_W-1:0];
                        r_state      <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    if (issue) begin
                        r_ra <= r_ra - 1'b1;
                    end else if (!r_dv) begin
                        r_state <= S_PLACE0;
                    end
                end
                S_PLACE0: begin
                    r_state <= S_PLACE1;
                end
                S_PLACE1: begin
                    r_count <= r_count + 1'b1;
                    r_ra    <= '0;
                    r_best  <= '0;
                    r_state <= S_LARGE;
                end
                S_FREE: begin
                    if (issue) begin
                        r_ra <= r_ra + 1'b1;
                    end
                    if (r_dv) begin
                        if (do_merge) begin
                            r_held.size <= merge_sum[SIZE_W] ? SAT32 : merge_sum[SIZE_W-1:0];
                        end else begin
                            if (r_hv) begin
                                r_wr <= r_wr + 1'b1;
                            end
                            r_held <= e_rel;
                            r_hv   <= 1'b1;
                        end
                    end else if (r_ra >= r_count) begin
                        r_state <= S_FREE_END;
                    end
                end
                S_FREE_END: begin
                    r_count <= CW'(r_wr) + 1'b1;
                    r_ra    <= '0;
                    r_best  <= '0;
                    r_state <= S_LARGE;
                end
                S_LARGE: begin
                    if (issue) begin
                        r_ra <= r_ra + 1'b1;
                    end
                    if (r_dv) begin
                        if (q.is_free && (q.size > r_best)) begin
                            r_best <= q.size;
                        end
                    end else if (r_ra >= r_count) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_ovld || !i_out_stall) begin
                        r_ostat  <= r_status;
                        r_opages <= r_page_total;
                        r_olarge <= r_best;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    bfta_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (q_bits)
    );

    bfta_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_out_valid       = r_ovld;
    assign o_status          = r_ostat;
    assign o_pages_requested = r_opages;
    assign o_largest_free    = r_olarge;
    assign o_cfg_ready       = 1'b1;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) && (r_count <= CW'(MAX_BLOCKS)))
        else $error("block count out of range");
    a_pages_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ##1 (r_page_total >= $past(r_page_total)))
        else $error("page total went down");
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !ram_we)
        else $error("table written while idle");
    a_div_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIV))
        else $error("divider result outside page growth");
`endif

endmodule
